// File: rtl/core/dcr_pkg.sv
`timescale 1ns / 1ps

package dcr_pkg;

  localparam int POS_W  = 18;
  localparam int VEL_W  = 19;
  localparam int LOSS_W = 12;
  localparam int STAT_W = 2;

  localparam logic [LOSS_W-1:0] LOSS_RESET = 12'd41;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [STAT_W-1:0] {
    ST_APPLIED    = 2'd0,
    ST_NOT_APPR   = 2'd1,
    ST_COINCIDENT = 2'd2
  } status_t;

endpackage

// File: rtl/core/dcr_in_if.sv
`timescale 1ns / 1ps

interface dcr_in_if;
  import dcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [POS_W-1:0]        pos_a_x;
  logic [POS_W-1:0]        pos_a_y;
  logic signed [VEL_W-1:0] vel_a_x;
  logic signed [VEL_W-1:0] vel_a_y;
  logic [POS_W-1:0]        pos_b_x;
  logic [POS_W-1:0]        pos_b_y;
  logic signed [VEL_W-1:0] vel_b_x;
  logic signed [VEL_W-1:0] vel_b_y;

  modport source (
    output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y,
    output pos_b_x, pos_b_y, vel_b_x, vel_b_y,
    input  ready
  );

  modport sink (
    input  valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y,
    input  pos_b_x, pos_b_y, vel_b_x, vel_b_y,
    output ready
  );

endinterface

// File: rtl/core/dcr_out_if.sv
`timescale 1ns / 1ps

interface dcr_out_if;
  import dcr_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] new_vel_a_x;
  logic signed [VEL_W-1:0] new_vel_a_y;
  logic signed [VEL_W-1:0] new_vel_b_x;
  logic signed [VEL_W-1:0] new_vel_b_y;
  logic [STAT_W-1:0]       status;

  modport source (
    output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, status,
    input  ready
  );

  modport sink (
    input  valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, status,
    output ready
  );

endinterface

// File: rtl/core/dcr_sqrt.sv
`timescale 1ns / 1ps

module dcr_sqrt #(
  parameter int IN_W = 38
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   x,
  output logic [IN_W/2-1:0] root
);

  localparam int OUT_W = IN_W / 2;
  localparam int RW    = OUT_W + 2;

  logic [RW-1:0]    rem_r  [OUT_W-1];
  logic [IN_W-1:0]  xs_r   [OUT_W-1];
  logic [OUT_W-1:0] root_r [OUT_W];

  for (genvar gi = 0; gi < OUT_W; gi++) begin : g_st
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    cur;
    logic [RW-1:0]    trial;
    logic [IN_W-1:0]  x_in;
    logic [OUT_W-1:0] root_in;
    logic             ge;

    if (gi == 0) begin : g_first
      assign rem_in  = '0;
      assign x_in    = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[gi-1];
      assign x_in    = xs_r[gi-1];
      assign root_in = root_r[gi-1];
    end

    assign cur   = {rem_in[RW-3:0], x_in[IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[gi] <= {root_in[OUT_W-2:0], ge};
      end
    end

    if (gi < OUT_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[gi] <= ge ? (cur - trial) : cur;
          xs_r[gi]  <= {x_in[IN_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

// File: rtl/core/dcr_div.sv
`timescale 1ns / 1ps

module dcr_div #(
  parameter int NUM_W = 39,
  parameter int DEN_W = 20,
  parameter int Q_W   = 19
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  localparam int RW = DEN_W + Q_W;

  logic [RW-1:0]    rem_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar gi = 0; gi < Q_W; gi++) begin : g_st
    localparam int K = Q_W - 1 - gi;
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    dsh;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic             ge;

    if (gi == 0) begin : g_first
      assign rem_in = RW'(num);
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[gi-1];
      assign den_in = den_r[gi-1];
      assign quo_in = quo_r[gi-1];
    end

    assign dsh = {{Q_W{1'b0}}, den_in} << K;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[gi] <= quo_in | (Q_W'(ge) << K);
      end
    end

    if (gi < Q_W - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[gi] <= ge ? (rem_in - dsh) : rem_in;
          den_r[gi] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

// File: rtl/core/dcr_delay.sv
`timescale 1ns / 1ps

module dcr_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// File: rtl/core/disc_collision_response.sv
// Throughput: one beat per cycle while the output is not stalled; the 51-stage pipeline is set
// by the 27-step distance root followed by the 17-step normal divider.
// A stalled output freezes the whole pipeline, and input ready drops with it.
// Reset clears all valid bits and loads 41 into the impact loss register.
`timescale 1ns / 1ps

module disc_collision_response (
  input  logic                       clk,
  input  logic                       rst_n,
  dcr_in_if.sink                     in_ch,
  dcr_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [dcr_pkg::LOSS_W-1:0] cfg_wdata
);
  import dcr_pkg::*;

  localparam int NST = 51;

  function automatic logic signed [27:0] rnd30(input logic signed [56:0] v);
    logic [56:0] mag;
    logic [26:0] q;
    mag = v[56] ? 57'(-v) : 57'(v);
    q = 27'((mag + (57'd1 << 29)) >> 30);
    rnd30 = v[56] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic logic signed [VEL_W-1:0] sat19(input logic signed [28:0] v);
    logic signed [VEL_W-1:0] r;
    priority if (v > 29'sd262143) begin
      r = VEL_MAX;
    end else if (v < -29'sd262144) begin
      r = VEL_MIN;
    end else begin
      r = v[VEL_W-1:0];
    end
    sat19 = r;
  endfunction

  logic [LOSS_W-1:0] loss_r;
  logic [NST:1]      vld_r;
  logic              adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loss_r <= LOSS_RESET;
    end else if (cfg_we) begin
      loss_r <= cfg_wdata;
    end
  end

  assign adv = !vld_r[NST] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_ch.valid};
    end
  end

  // Stage 1: input registers.
  logic [POS_W-1:0]        s1_pax_r, s1_pay_r, s1_pbx_r, s1_pby_r;
  logic signed [VEL_W-1:0] s1_vax_r, s1_vay_r, s1_vbx_r, s1_vby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pax_r <= in_ch.pos_a_x;
      s1_pay_r <= in_ch.pos_a_y;
      s1_pbx_r <= in_ch.pos_b_x;
      s1_pby_r <= in_ch.pos_b_y;
      s1_vax_r <= in_ch.vel_a_x;
      s1_vay_r <= in_ch.vel_a_y;
      s1_vbx_r <= in_ch.vel_b_x;
      s1_vby_r <= in_ch.vel_b_y;
    end
  end

  logic signed [POS_W:0] dx, dy;
  logic [POS_W-1:0]      adx, ady;
  logic [VEL_W-1:0]      av_ax, av_ay, av_bx, av_by;

  assign dx    = $signed({1'b0, s1_pbx_r}) - $signed({1'b0, s1_pax_r});
  assign dy    = $signed({1'b0, s1_pby_r}) - $signed({1'b0, s1_pay_r});
  assign adx   = dx[POS_W] ? POS_W'(-dx) : POS_W'(dx);
  assign ady   = dy[POS_W] ? POS_W'(-dy) : POS_W'(dy);
  assign av_ax = s1_vax_r[VEL_W-1] ? VEL_W'(-s1_vax_r) : VEL_W'(s1_vax_r);
  assign av_ay = s1_vay_r[VEL_W-1] ? VEL_W'(-s1_vay_r) : VEL_W'(s1_vay_r);
  assign av_bx = s1_vbx_r[VEL_W-1] ? VEL_W'(-s1_vbx_r) : VEL_W'(s1_vbx_r);
  assign av_by = s1_vby_r[VEL_W-1] ? VEL_W'(-s1_vby_r) : VEL_W'(s1_vby_r);

  // Stage 2: squares.
  logic [35:0]             s2_sqdx_r, s2_sqdy_r;
  logic [37:0]             s2_sqax_r, s2_sqay_r, s2_sqbx_r, s2_sqby_r;
  logic [POS_W-1:0]        s2_adx_r, s2_ady_r;
  logic                    s2_sdx_r, s2_sdy_r, s2_coinc_r;
  logic [VEL_W-1:0]        s2_av_ax_r, s2_av_ay_r, s2_av_bx_r, s2_av_by_r;
  logic signed [VEL_W-1:0] s2_vax_r, s2_vay_r, s2_vbx_r, s2_vby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sqdx_r  <= adx * adx;
      s2_sqdy_r  <= ady * ady;
      s2_sqax_r  <= av_ax * av_ax;
      s2_sqay_r  <= av_ay * av_ay;
      s2_sqbx_r  <= av_bx * av_bx;
      s2_sqby_r  <= av_by * av_by;
      s2_adx_r   <= adx;
      s2_ady_r   <= ady;
      s2_sdx_r   <= dx[POS_W];
      s2_sdy_r   <= dy[POS_W];
      s2_coinc_r <= (adx == '0) && (ady == '0);
      s2_av_ax_r <= av_ax;
      s2_av_ay_r <= av_ay;
      s2_av_bx_r <= av_bx;
      s2_av_by_r <= av_by;
      s2_vax_r   <= s1_vax_r;
      s2_vay_r   <= s1_vay_r;
      s2_vbx_r   <= s1_vbx_r;
      s2_vby_r   <= s1_vby_r;
    end
  end

  logic [36:0] d2;
  logic [53:0] len_sq;
  logic [37:0] spd_sq_a, spd_sq_b;
  logic [26:0] len;
  logic [18:0] spd_a, spd_b;

  assign d2       = 37'(s2_sqdx_r) + 37'(s2_sqdy_r);
  assign len_sq   = {1'b0, d2, 16'd0};
  assign spd_sq_a = s2_sqax_r + s2_sqay_r;
  assign spd_sq_b = s2_sqbx_r + s2_sqby_r;

  dcr_sqrt #(.IN_W(54)) u_sqrt_len (.clk(clk), .en(adv), .x(len_sq),   .root(len));
  dcr_sqrt #(.IN_W(38)) u_sqrt_a   (.clk(clk), .en(adv), .x(spd_sq_a), .root(spd_a));
  dcr_sqrt #(.IN_W(38)) u_sqrt_b   (.clk(clk), .en(adv), .x(spd_sq_b), .root(spd_b));

  logic [POS_W-1:0] adx29, ady29;

  dcr_delay #(.W(2*POS_W), .DEPTH(27)) u_dl_adx (
    .clk(clk), .en(adv), .d({s2_adx_r, s2_ady_r}), .q({adx29, ady29})
  );

  logic signed [VEL_W-1:0] vax46, vay46, vbx46, vby46;
  logic                    sdx46, sdy46, coinc46;

  dcr_delay #(.W(4*VEL_W+3), .DEPTH(44)) u_dl_side (
    .clk(clk), .en(adv),
    .d({s2_vax_r, s2_vay_r, s2_vbx_r, s2_vby_r, s2_sdx_r, s2_sdy_r, s2_coinc_r}),
    .q({vax46, vay46, vbx46, vby46, sdx46, sdy46, coinc46})
  );

  logic [VEL_W-1:0] av_ax21, av_ay21, av_bx21, av_by21;
  logic             sg_ax21, sg_ay21, sg_bx21, sg_by21;

  dcr_delay #(.W(4*VEL_W+4), .DEPTH(19)) u_dl_spd (
    .clk(clk), .en(adv),
    .d({s2_av_ax_r, s2_av_ay_r, s2_av_bx_r, s2_av_by_r,
        s2_vax_r[VEL_W-1], s2_vay_r[VEL_W-1], s2_vbx_r[VEL_W-1], s2_vby_r[VEL_W-1]}),
    .q({av_ax21, av_ay21, av_bx21, av_by21, sg_ax21, sg_ay21, sg_bx21, sg_by21})
  );

  // Speed reduction: scale each velocity by (s - loss) / s, or zero it when s is zero or below loss.
  logic [18:0] keep_a, keep_b;
  logic        zero_a, zero_b;

  assign zero_a = (spd_a == '0) || (spd_a < 19'(loss_r));
  assign zero_b = (spd_b == '0) || (spd_b < 19'(loss_r));
  assign keep_a = spd_a - 19'(loss_r);
  assign keep_b = spd_b - 19'(loss_r);

  logic [37:0] s22_pax_r, s22_pay_r, s22_pbx_r, s22_pby_r;
  logic [18:0] s22_sa_r, s22_sb_r;
  logic        s22_za_r, s22_zb_r;
  logic [3:0]  s22_sg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s22_pax_r <= av_ax21 * keep_a;
      s22_pay_r <= av_ay21 * keep_a;
      s22_pbx_r <= av_bx21 * keep_b;
      s22_pby_r <= av_by21 * keep_b;
      s22_sa_r  <= spd_a;
      s22_sb_r  <= spd_b;
      s22_za_r  <= zero_a;
      s22_zb_r  <= zero_b;
      s22_sg_r  <= {sg_ax21, sg_ay21, sg_bx21, sg_by21};
    end
  end

  logic [38:0] num_ax, num_ay, num_bx, num_by;
  logic [19:0] den_a, den_b;
  logic [18:0] q_ax, q_ay, q_bx, q_by;

  assign num_ax = {s22_pax_r, 1'b0} + 39'(s22_sa_r);
  assign num_ay = {s22_pay_r, 1'b0} + 39'(s22_sa_r);
  assign num_bx = {s22_pbx_r, 1'b0} + 39'(s22_sb_r);
  assign num_by = {s22_pby_r, 1'b0} + 39'(s22_sb_r);
  assign den_a  = {s22_sa_r, 1'b0};
  assign den_b  = {s22_sb_r, 1'b0};

  dcr_div #(.NUM_W(39), .DEN_W(20), .Q_W(19)) u_div_ax (
    .clk(clk), .en(adv), .num(num_ax), .den(den_a), .quo(q_ax));
  dcr_div #(.NUM_W(39), .DEN_W(20), .Q_W(19)) u_div_ay (
    .clk(clk), .en(adv), .num(num_ay), .den(den_a), .quo(q_ay));
  dcr_div #(.NUM_W(39), .DEN_W(20), .Q_W(19)) u_div_bx (
    .clk(clk), .en(adv), .num(num_bx), .den(den_b), .quo(q_bx));
  dcr_div #(.NUM_W(39), .DEN_W(20), .Q_W(19)) u_div_by (
    .clk(clk), .en(adv), .num(num_by), .den(den_b), .quo(q_by));

  logic       za41, zb41;
  logic [3:0] sg41;

  dcr_delay #(.W(6), .DEPTH(19)) u_dl_cut (
    .clk(clk), .en(adv), .d({s22_za_r, s22_zb_r, s22_sg_r}), .q({za41, zb41, sg41})
  );

  logic signed [VEL_W-1:0] s42_cax_r, s42_cay_r, s42_cbx_r, s42_cby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s42_cax_r <= za41 ? '0 : (sg41[3] ? -q_ax : q_ax);
      s42_cay_r <= za41 ? '0 : (sg41[2] ? -q_ay : q_ay);
      s42_cbx_r <= zb41 ? '0 : (sg41[1] ? -q_bx : q_bx);
      s42_cby_r <= zb41 ? '0 : (sg41[0] ? -q_by : q_by);
    end
  end

  logic signed [VEL_W-1:0] cax47, cay47, cbx47, cby47;

  dcr_delay #(.W(4*VEL_W), .DEPTH(5)) u_dl_vc (
    .clk(clk), .en(adv),
    .d({s42_cax_r, s42_cay_r, s42_cbx_r, s42_cby_r}),
    .q({cax47, cay47, cbx47, cby47})
  );

  // Unit normal: n = round(d * 2^23 / len).
  logic [42:0] num_nx, num_ny;
  logic [27:0] den_n;
  logic [16:0] q_nx, q_ny;

  assign num_nx = {1'b0, adx29, 24'd0} + 43'(len);
  assign num_ny = {1'b0, ady29, 24'd0} + 43'(len);
  assign den_n  = {len, 1'b0};

  dcr_div #(.NUM_W(43), .DEN_W(28), .Q_W(17)) u_div_nx (
    .clk(clk), .en(adv), .num(num_nx), .den(den_n), .quo(q_nx));
  dcr_div #(.NUM_W(43), .DEN_W(28), .Q_W(17)) u_div_ny (
    .clk(clk), .en(adv), .num(num_ny), .den(den_n), .quo(q_ny));

  logic signed [17:0]      s47_nx_r, s47_ny_r;
  logic signed [VEL_W-1:0] s47_vax_r, s47_vay_r, s47_vbx_r, s47_vby_r;
  logic                    s47_coinc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s47_nx_r    <= sdx46 ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
      s47_ny_r    <= sdy46 ? -$signed({1'b0, q_ny}) : $signed({1'b0, q_ny});
      s47_vax_r   <= vax46;
      s47_vay_r   <= vay46;
      s47_vbx_r   <= vbx46;
      s47_vby_r   <= vby46;
      s47_coinc_r <= coinc46;
    end
  end

  logic signed [20:0] dvx, dvy;

  assign dvx = 21'(cbx47) - 21'(cax47);
  assign dvy = 21'(cby47) - 21'(cay47);

  logic signed [36:0]      s48_pax_r, s48_pay_r, s48_pbx_r, s48_pby_r;
  logic signed [38:0]      s48_pjx_r, s48_pjy_r;
  logic signed [17:0]      s48_nx_r, s48_ny_r;
  logic signed [VEL_W-1:0] s48_cax_r, s48_cay_r, s48_cbx_r, s48_cby_r;
  logic signed [VEL_W-1:0] s48_vax_r, s48_vay_r, s48_vbx_r, s48_vby_r;
  logic                    s48_coinc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s48_pax_r   <= s47_vax_r * s47_nx_r;
      s48_pay_r   <= s47_vay_r * s47_ny_r;
      s48_pbx_r   <= s47_vbx_r * s47_nx_r;
      s48_pby_r   <= s47_vby_r * s47_ny_r;
      s48_pjx_r   <= dvx * s47_nx_r;
      s48_pjy_r   <= dvy * s47_ny_r;
      s48_nx_r    <= s47_nx_r;
      s48_ny_r    <= s47_ny_r;
      s48_cax_r   <= cax47;
      s48_cay_r   <= cay47;
      s48_cbx_r   <= cbx47;
      s48_cby_r   <= cby47;
      s48_vax_r   <= s47_vax_r;
      s48_vay_r   <= s47_vay_r;
      s48_vbx_r   <= s47_vbx_r;
      s48_vby_r   <= s47_vby_r;
      s48_coinc_r <= s47_coinc_r;
    end
  end

  logic signed [37:0] pr_a, pr_b;
  logic signed [38:0] pr_diff, proj;
  logic               not_appr;
  status_t            stat48;

  assign pr_a     = 38'(s48_pax_r) + 38'(s48_pay_r);
  assign pr_b     = 38'(s48_pbx_r) + 38'(s48_pby_r);
  assign pr_diff  = 39'(pr_a) - 39'(pr_b);
  assign proj     = 39'(s48_pjx_r) + 39'(s48_pjy_r);
  assign not_appr = ((pr_a <= 0) && (pr_b >= 0)) || (pr_diff < 0);
  assign stat48   = s48_coinc_r ? ST_COINCIDENT : (not_appr ? ST_NOT_APPR : ST_APPLIED);

  logic signed [38:0]      s49_proj_r;
  status_t                 s49_stat_r;
  logic signed [17:0]      s49_nx_r, s49_ny_r;
  logic signed [VEL_W-1:0] s49_cax_r, s49_cay_r, s49_cbx_r, s49_cby_r;
  logic signed [VEL_W-1:0] s49_vax_r, s49_vay_r, s49_vbx_r, s49_vby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s49_proj_r <= proj;
      s49_stat_r <= stat48;
      s49_nx_r   <= s48_nx_r;
      s49_ny_r   <= s48_ny_r;
      s49_cax_r  <= s48_cax_r;
      s49_cay_r  <= s48_cay_r;
      s49_cbx_r  <= s48_cbx_r;
      s49_cby_r  <= s48_cby_r;
      s49_vax_r  <= s48_vax_r;
      s49_vay_r  <= s48_vay_r;
      s49_vbx_r  <= s48_vbx_r;
      s49_vby_r  <= s48_vby_r;
    end
  end

  logic signed [56:0]      s50_ex_r, s50_ey_r;
  status_t                 s50_stat_r;
  logic signed [VEL_W-1:0] s50_cax_r, s50_cay_r, s50_cbx_r, s50_cby_r;
  logic signed [VEL_W-1:0] s50_vax_r, s50_vay_r, s50_vbx_r, s50_vby_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s50_ex_r   <= s49_nx_r * s49_proj_r;
      s50_ey_r   <= s49_ny_r * s49_proj_r;
      s50_stat_r <= s49_stat_r;
      s50_cax_r  <= s49_cax_r;
      s50_cay_r  <= s49_cay_r;
      s50_cbx_r  <= s49_cbx_r;
      s50_cby_r  <= s49_cby_r;
      s50_vax_r  <= s49_vax_r;
      s50_vay_r  <= s49_vay_r;
      s50_vbx_r  <= s49_vbx_r;
      s50_vby_r  <= s49_vby_r;
    end
  end

  logic signed [27:0]      ex, ey;
  logic signed [VEL_W-1:0] nax, nay, nbx, nby;
  logic                    apply;

  assign ex    = rnd30(s50_ex_r);
  assign ey    = rnd30(s50_ey_r);
  assign nax   = sat19(29'(s50_cax_r) + 29'(ex));
  assign nay   = sat19(29'(s50_cay_r) + 29'(ey));
  assign nbx   = sat19(29'(s50_cbx_r) - 29'(ex));
  assign nby   = sat19(29'(s50_cby_r) - 29'(ey));
  assign apply = (s50_stat_r == ST_APPLIED);

  logic signed [VEL_W-1:0] o_ax_r, o_ay_r, o_bx_r, o_by_r;
  status_t                 o_stat_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_ax_r   <= apply ? nax : s50_vax_r;
      o_ay_r   <= apply ? nay : s50_vay_r;
      o_bx_r   <= apply ? nbx : s50_vbx_r;
      o_by_r   <= apply ? nby : s50_vby_r;
      o_stat_r <= s50_stat_r;
    end
  end

  assign out_ch.valid       = vld_r[NST];
  assign out_ch.new_vel_a_x = o_ax_r;
  assign out_ch.new_vel_a_y = o_ay_r;
  assign out_ch.new_vel_b_x = o_bx_r;
  assign out_ch.new_vel_b_y = o_by_r;
  assign out_ch.status      = o_stat_r;

endmodule

// File: rtl/core/dcr_chk.sv
`timescale 1ns / 1ps

module dcr_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dcr_pkg::VEL_W-1:0]  out_vel_a_x,
  input logic [dcr_pkg::STAT_W-1:0]        out_status
);
  import dcr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_vel_a_x))
    else $error("Stalled result beat changed.");

  a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("Input stalled while the output sink was ready.");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !out_ready |-> !out_valid)
    else $error("Input ready while a result beat was held.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result beat valid after reset.");

endmodule

bind disc_collision_response dcr_chk u_dcr_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_vel_a_x (out_ch.new_vel_a_x),
  .out_status  (out_ch.status)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import dcr_pkg::*;

  localparam int LATENCY = 50;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_PHASE_ITEMS = 147;

  typedef struct packed {
    logic [POS_W-1:0]        pa_x;
    logic [POS_W-1:0]        pa_y;
    logic signed [VEL_W-1:0] va_x;
    logic signed [VEL_W-1:0] va_y;
    logic [POS_W-1:0]        pb_x;
    logic [POS_W-1:0]        pb_y;
    logic signed [VEL_W-1:0] vb_x;
    logic signed [VEL_W-1:0] vb_y;
    bit                      typed;
    status_t                 typed_st;
  } pair_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] na_x;
    logic signed [VEL_W-1:0] na_y;
    logic signed [VEL_W-1:0] nb_x;
    logic signed [VEL_W-1:0] nb_y;
    status_t                 st;
  } resp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LOSS_W-1:0] cfg_wdata;

  dcr_in_if  in_ch ();
  dcr_out_if out_ch ();

  disc_collision_response uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  resp_t       pending_resp[$];
  logic [LOSS_W-1:0] cur_loss;
  int          errors;
  int          n_sent;
  int          n_recv;
  int          n_applied;
  int          n_sat;
  int          cycles;
  int          hold_req;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint isqrt(longint x);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint shr_near(longint v, int s);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) << (s - 1))) >> s;
    return (v < 0) ? -q : q;
  endfunction

  function automatic longint clamp_vel(longint v);
    if (v > longint'(VEL_MAX)) return longint'(VEL_MAX);
    if (v < longint'(VEL_MIN)) return longint'(VEL_MIN);
    return v;
  endfunction

  function automatic void reduce_speed(inout longint vx, inout longint vy, input longint loss);
    longint s;
    s = isqrt(vx * vx + vy * vy);
    if (s == 0 || s < loss) begin
      vx = 0;
      vy = 0;
    end else begin
      vx = div_near(vx * (s - loss), s);
      vy = div_near(vy * (s - loss), s);
    end
  endfunction

  function automatic resp_t respond(pair_t p, logic [LOSS_W-1:0] loss);
    resp_t  r;
    longint dx, dy, len, nx, ny, pr1, pr2, proj, ex, ey;
    longint vax, vay, vbx, vby;
    longint sax, say, sbx, sby;
    vax = p.va_x;
    vay = p.va_y;
    vbx = p.vb_x;
    vby = p.vb_y;
    dx = longint'(p.pb_x) - longint'(p.pa_x);
    dy = longint'(p.pb_y) - longint'(p.pa_y);
    r.st = ST_NOT_APPR;
    if (dx == 0 && dy == 0) begin
      r.st = ST_COINCIDENT;
    end else begin
      len = isqrt((dx * dx + dy * dy) << 16);
      nx = div_near(dx * (longint'(1) << 23), len);
      ny = div_near(dy * (longint'(1) << 23), len);
      pr1 = vax * nx + vay * ny;
      pr2 = vbx * nx + vby * ny;
      if (!((pr1 <= 0 && pr2 >= 0) || (pr1 - pr2) < 0)) begin
        reduce_speed(vax, vay, longint'(loss));
        reduce_speed(vbx, vby, longint'(loss));
        proj = (vbx - vax) * nx + (vby - vay) * ny;
        ex = shr_near(nx * proj, 30);
        ey = shr_near(ny * proj, 30);
        sax = clamp_vel(vax + ex);
        say = clamp_vel(vay + ey);
        sbx = clamp_vel(vbx - ex);
        sby = clamp_vel(vby - ey);
        if (sax != vax + ex || say != vay + ey || sbx != vbx - ex || sby != vby - ey)
          n_sat++;
        vax = sax;
        vay = say;
        vbx = sbx;
        vby = sby;
        r.st = ST_APPLIED;
      end
    end
    r.na_x = vax[VEL_W-1:0];
    r.na_y = vay[VEL_W-1:0];
    r.nb_x = vbx[VEL_W-1:0];
    r.nb_y = vby[VEL_W-1:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] near_pos(logic [POS_W-1:0] base, int spread);
    int v;
    v = int'(base) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > 262143) v = 262143;
    return v[POS_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] rand_vel(int kind);
    int m;
    case (kind)
      0: m = 64;
      1: m = 8192;
      default: return VEL_W'($urandom());
    endcase
    return VEL_W'($urandom_range(0, 2 * m) - m);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int    kind;
    int    spread;
    p.typed = 1'b0;
    p.typed_st = ST_APPLIED;
    if ($urandom_range(0, 9) < 7) begin
      kind = $urandom_range(0, 2);
      spread = ($urandom_range(0, 3) == 0) ? 4 : 4096;
      p.pa_x = POS_W'($urandom());
      p.pa_y = POS_W'($urandom());
      p.pb_x = near_pos(p.pa_x, spread);
      p.pb_y = near_pos(p.pa_y, spread);
      p.va_x = rand_vel(kind);
      p.va_y = rand_vel(kind);
      p.vb_x = rand_vel(kind);
      p.vb_y = rand_vel(kind);
      if (p.pb_x > p.pa_x && p.va_x < 0) p.va_x = -p.va_x;
      if (p.pb_x < p.pa_x && p.va_x > 0) p.va_x = -p.va_x;
    end else begin
      p.pa_x = POS_W'($urandom());
      p.pa_y = POS_W'($urandom());
      p.pb_x = POS_W'($urandom());
      p.pb_y = POS_W'($urandom());
      p.va_x = VEL_W'($urandom());
      p.va_y = VEL_W'($urandom());
      p.vb_x = VEL_W'($urandom());
      p.vb_y = VEL_W'($urandom());
      if ($urandom_range(0, 15) == 0) begin
        p.pb_x = p.pa_x;
        p.pb_y = p.pa_y;
      end
    end
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    resp_t e;
    int    gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.pos_a_x <= p.pa_x;
    in_ch.pos_a_y <= p.pa_y;
    in_ch.vel_a_x <= p.va_x;
    in_ch.vel_a_y <= p.va_y;
    in_ch.pos_b_x <= p.pb_x;
    in_ch.pos_b_y <= p.pb_y;
    in_ch.vel_b_x <= p.vb_x;
    in_ch.vel_b_y <= p.vb_y;
    do @(posedge clk); while (!in_ch.ready);
    if (p.typed) begin
      e.na_x = p.va_x;
      e.na_y = p.va_y;
      e.nb_x = p.vb_x;
      e.nb_y = p.vb_y;
      e.st   = p.typed_st;
    end else begin
      e = respond(p, cur_loss);
    end
    if (e.st == ST_APPLIED) n_applied++;
    pending_resp.push_back(e);
    n_sent++;
  endtask

  task automatic drain_and_set_loss(logic [LOSS_W-1:0] v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_loss = v;
  endtask

  int hold_seen;
  int hold_cnt;
  int ready_pct;
  int pct_cnt;

  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_recv++;
      if (pending_resp.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = pending_resp.pop_front();
        if (out_ch.new_vel_a_x !== e.na_x) begin
          $error("new_vel_a_x expected %0d actual %0d", e.na_x, out_ch.new_vel_a_x);
          errors++;
        end
        if (out_ch.new_vel_a_y !== e.na_y) begin
          $error("new_vel_a_y expected %0d actual %0d", e.na_y, out_ch.new_vel_a_y);
          errors++;
        end
        if (out_ch.new_vel_b_x !== e.nb_x) begin
          $error("new_vel_b_x expected %0d actual %0d", e.nb_x, out_ch.new_vel_b_x);
          errors++;
        end
        if (out_ch.new_vel_b_y !== e.nb_y) begin
          $error("new_vel_b_y expected %0d actual %0d", e.nb_y, out_ch.new_vel_b_y);
          errors++;
        end
        if (out_ch.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_ch.status);
          errors++;
        end
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (pct_cnt == 0) begin
      case ($urandom_range(0, 2))
        0: ready_pct = 100;
        1: ready_pct = 70;
        default: ready_pct = 25;
      endcase
      pct_cnt = $urandom_range(50, 300);
    end else begin
      pct_cnt--;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  pair_t dir_tab[14];

  initial begin
    logic [LOSS_W-1:0] loss_plan[5];
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    n_applied = 0;
    n_sat = 0;
    cycles = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_cnt = 0;
    ready_pct = 100;
    pct_cnt = 0;
    burst_left = 0;
    cur_loss = LOSS_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    out_ch.ready = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pos_a_x = '0;
    in_ch.pos_a_y = '0;
    in_ch.vel_a_x = '0;
    in_ch.vel_a_y = '0;
    in_ch.pos_b_x = '0;
    in_ch.pos_b_y = '0;
    in_ch.vel_b_x = '0;
    in_ch.vel_b_y = '0;

    dir_tab = '{
      '{0, 0, 19'sd4096, -19'sd4096, 0, 0, 19'sd5, 19'sd7, 1'b1, ST_COINCIDENT},
      '{262143, 262143, VEL_MAX, VEL_MIN, 262143, 262143, VEL_MIN, VEL_MAX,
        1'b1, ST_COINCIDENT},
      '{100, 100, 0, 0, 900, 100, 0, 0, 1'b1, ST_NOT_APPR},
      '{25600, 25600, 19'sd4096, 0, 30720, 25600, -19'sd4096, 0, 1'b0, ST_APPLIED},
      '{25600, 25600, -19'sd4096, 0, 30720, 25600, 19'sd4096, 0, 1'b0, ST_APPLIED},
      '{0, 0, VEL_MAX, VEL_MAX, 262143, 262143, VEL_MIN, VEL_MIN, 1'b0, ST_APPLIED},
      '{262143, 0, VEL_MIN, VEL_MAX, 0, 262143, VEL_MAX, VEL_MIN, 1'b0, ST_APPLIED},
      '{1000, 1000, 19'sd20, 19'sd10, 1001, 1000, -19'sd15, 0, 1'b0, ST_APPLIED},
      '{5000, 5000, 19'sd3000, 19'sd3000, 5100, 5100, 0, 0, 1'b0, ST_APPLIED},
      '{5000, 5000, 19'sd3000, 0, 5100, 5000, 19'sd5000, 0, 1'b0, ST_APPLIED},
      '{7000, 7000, 0, 19'sd8000, 7000, 7200, 19'sd10, -19'sd8000, 1'b0, ST_APPLIED},
      '{0, 262143, VEL_MAX, 0, 1, 262143, VEL_MIN, 0, 1'b0, ST_APPLIED},
      '{40000, 40000, 19'sd41, 0, 40100, 40000, -19'sd40, 0, 1'b0, ST_APPLIED},
      '{12345, 54321, -19'sd700, 19'sd900, 12000, 54000, 19'sd300, -19'sd100,
        1'b0, ST_APPLIED}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_pair(dir_tab[i]);

    loss_plan = '{12'd0, 12'd4095, LOSS_W'($urandom()), 12'd1, LOSS_RESET};
    foreach (loss_plan[ph]) begin
      drain_and_set_loss(loss_plan[ph]);
      if (ph == 1) hold_req++;
      for (int k = 0; k < N_PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 60) begin
          in_ch.valid <= 1'b0;
          burst_left = 0;
          while (pending_resp.size() != 0) @(posedge clk);
        end
        send_pair(rand_pair());
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d disc pairs over 6 impact loss settings, %0d results checked.",
             n_sent, n_recv);
    $display("Collisions applied: %0d, saturating responses: %0d.", n_applied, n_sat);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
